/* hdl/can_fragment_reassembler_top_macros.svh */
// Assertion macros for the reassembler's top-level RTL file.
// Needs nothing else; included by the top module, which checks its own logic.
`ifndef CAN_FRAGMENT_REASSEMBLER_TOP_MACROS_SVH
`define CAN_FRAGMENT_REASSEMBLER_TOP_MACROS_SVH

// Implication that must hold at every clock edge once out of reset.
`define CFR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define CFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/cfr_pkg.sv */
// Shared types and constants for the CAN fragment reassembler.
// Depends on nothing; used by every module of the block.
package cfr_pkg;

  localparam logic [2:0] ST_PARTIAL = 3'd0;
  localparam logic [2:0] ST_DROP    = 3'd1;
  localparam logic [2:0] ST_ORPHAN  = 3'd2;
  localparam logic [2:0] ST_CRCFAIL = 3'd3;
  localparam logic [2:0] ST_WORD    = 3'd4;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam int unsigned WORD_LIMIT = 64;

  // Byte-serial CRC unit control.
  typedef struct packed {
    logic       clear;
    logic       feed;
    logic [7:0] data;
  } crc_ctl_t;

  // Fold one byte into CRC-16/CCITT-FALSE, eight bit steps.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

/* hdl/cfr_crc.sv */
// Byte-serial CRC-16/CCITT-FALSE accumulator, one byte per cycle while feed is high.
// Depends on cfr_pkg.
module cfr_crc (
  input  logic             clk,
  input  logic             rst_n,
  input  cfr_pkg::crc_ctl_t ctl,
  output logic [15:0]      crc
);
  logic [15:0] crc_r, crc_nxt;

  // Clear to the seed or fold in one byte.
  always_comb begin
    crc_nxt = crc_r;
    if (ctl.clear) begin
      crc_nxt = cfr_pkg::CRC_INIT;
    end else if (ctl.feed) begin
      crc_nxt = cfr_pkg::crc_byte(crc_r, ctl.data);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= cfr_pkg::CRC_INIT;
    end else begin
      crc_r <= crc_nxt;
    end
  end

  assign crc = crc_r;
endmodule

/* hdl/can_fragment_reassembler_top.sv */
// CAN fragment reassembler: slot matching, byte-serial body store and CRC check.
// Steps of a frame: lookup (S_EVAL), byte writes (S_WRITE), then for a last frame that leaves
// two bytes or more the body CRC (S_CRC), trailer check (S_TRL) and word output (S_OUT);
// each frame's result or results are registered and leave through S_RES or S_OUT.
// One frame at a time (busy until its last result).
// Synchronous active-low reset clears slots, counters and control, not the store; no stall.
`include "can_fragment_reassembler_top_macros.svh"
module can_fragment_reassembler_top #(
  parameter int SLOT_COUNT     = 4,
  parameter int MAX_BODY_BYTES = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [28:0] in_can_id,
  input  logic [3:0]  in_frame_len,
  input  logic [63:0] in_frame_data,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [7:0]  out_src_node,
  output logic [7:0]  out_src_port,
  output logic [63:0] out_body_word,
  output logic [3:0]  out_word_bytes,
  output logic [8:0]  out_body_length,
  output logic        out_last,
  output logic [31:0] out_drop_count,
  output logic [31:0] out_orphan_count,
  output logic [31:0] out_crc_fail_count
);
  localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int FW = $clog2(MAX_BODY_BYTES + 1);
  localparam int BW = $clog2(MAX_BODY_BYTES);
  localparam int AW = SW + BW;
  localparam int DEPTH = SLOT_COUNT * (1 << BW);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EVAL  = 3'd1;
  localparam logic [2:0] S_WRITE = 3'd2;
  localparam logic [2:0] S_CRC   = 3'd3;
  localparam logic [2:0] S_TRL   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;
  localparam logic [2:0] S_RES   = 3'd6;

  logic [2:0] state_r;

  // Slot table.
  logic [SLOT_COUNT-1:0] act_r;
  logic [7:0] snode_r [SLOT_COUNT];
  logic [7:0] sport_r [SLOT_COUNT];
  logic [4:0] sseq_r  [SLOT_COUNT];
  logic [5:0] sidx_r  [SLOT_COUNT];
  logic [FW-1:0] sfill_r [SLOT_COUNT];

  // Latched frame.
  logic [7:0] node_r, port_r;
  logic first_r, fin_r;
  logic [4:0] seq_r;
  logic [5:0] idx_r;
  logic [3:0] len_r;
  logic [63:0] data_r;

  logic [SW-1:0] slot_r;
  logic [FW-1:0] fill_r;
  logic [FW-1:0] ptr_r;
  logic [FW-1:0] blen_r;
  logic [3:0] bcnt_r;
  logic [63:0] word_r;
  logic [2:0] rstat_r;
  logic [7:0] want_r;
  logic [6:0] wcnt_r;
  logic rdv_r;

  logic [31:0] drop_r, orph_r, crcf_r;

  // Body store.
  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;
  logic we;
  logic [AW-1:0] waddr, raddr;
  logic re;

  // Output registers.
  logic out_valid_r, out_last_r;
  logic [2:0] out_status_r;
  logic [63:0] out_word_r;
  logic [3:0] out_nb_r;
  logic [8:0] out_blen_r;

  cfr_pkg::crc_ctl_t cctl;
  logic [15:0] crc;

  cfr_crc u_crc (.clk(clk), .rst_n(rst_n), .ctl(cctl), .crc(crc));

  // Slot lookup on latched frame.
  logic hit, freef;
  logic [SW-1:0] hit_s, free_s;
  always_comb begin
    hit = 1'b0; hit_s = '0; freef = 1'b0; free_s = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (act_r[i] && snode_r[i] == node_r && sport_r[i] == port_r) begin
        hit = 1'b1; hit_s = SW'(i);
      end
      if (!act_r[i]) begin
        freef = 1'b1; free_s = SW'(i);
      end
    end
  end

  logic [SW-1:0] es;
  logic [4:0] eseq;
  logic [5:0] enidx;
  logic [FW-1:0] efill;
  logic [FW:0] esum;
  always_comb begin
    es = hit ? hit_s : free_s;
    eseq = (first_r) ? seq_r : sseq_r[es];
    enidx = (first_r) ? 6'd0 : sidx_r[es];
    efill = (first_r) ? '0 : sfill_r[es];
    esum = {1'b0, efill} + (FW+1)'(len_r);
  end

  // Byte-level helpers.
  logic [FW-1:0] ptr_inc;
  assign ptr_inc = ptr_r + FW'(1);
  assign busy = (state_r != S_IDLE);

  always_comb begin
    we = (state_r == S_WRITE) && (bcnt_r != len_r);
    waddr = {slot_r, fill_r[BW-1:0]};
    re = (state_r == S_CRC) || (state_r == S_TRL) || (state_r == S_OUT);
    raddr = {slot_r, ptr_r[BW-1:0]};
    cctl.clear = (state_r == S_EVAL);
    cctl.feed = rdv_r && (state_r == S_CRC);
    cctl.data = rdata_r;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= data_r[7:0];
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  function automatic logic [31:0] sat(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  // Main sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      act_r <= '0;
      drop_r <= '0; orph_r <= '0; crcf_r <= '0;
      out_valid_r <= 1'b0;
      rdv_r <= 1'b0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        snode_r[i] <= '0; sport_r[i] <= '0; sseq_r[i] <= '0;
        sidx_r[i] <= '0; sfill_r[i] <= '0;
      end
    end else begin
      out_valid_r <= 1'b0;
      rdv_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            node_r <= in_can_id[28:21];
            port_r <= in_can_id[20:13];
            first_r <= in_can_id[12];
            fin_r <= in_can_id[11];
            seq_r <= in_can_id[10:6];
            idx_r <= in_can_id[5:0];
            len_r <= (in_frame_len > 4'd8) ? 4'd8 : in_frame_len;
            data_r <= in_frame_data;
            state_r <= S_EVAL;
          end
        end
        S_EVAL: begin
          out_word_r <= '0; out_nb_r <= '0; out_blen_r <= '0; out_last_r <= 1'b1;
          slot_r <= es;
          fill_r <= efill;
          bcnt_r <= '0;
          state_r <= S_RES;
          if (first_r && !hit && !freef) begin
            drop_r <= sat(drop_r); rstat_r <= cfr_pkg::ST_DROP;
          end else if (!first_r && !hit) begin
            orph_r <= sat(orph_r); rstat_r <= cfr_pkg::ST_ORPHAN;
          end else begin
            if (first_r) begin
              snode_r[es] <= node_r; sport_r[es] <= port_r; sseq_r[es] <= seq_r;
            end
            if (idx_r != enidx || seq_r != eseq
                || esum > (FW+1)'(MAX_BODY_BYTES)) begin
              drop_r <= sat(drop_r); rstat_r <= cfr_pkg::ST_DROP;
              act_r[es] <= 1'b0;
            end else begin
              act_r[es] <= !fin_r;
              sidx_r[es] <= enidx + 6'd1;
              sfill_r[es] <= esum[FW-1:0];
              state_r <= S_WRITE;
            end
          end
        end
        S_WRITE: begin
          if (bcnt_r != len_r) begin
            data_r <= {8'h00, data_r[63:8]};
            fill_r <= fill_r + FW'(1);
            bcnt_r <= bcnt_r + 4'd1;
          end else if (!fin_r) begin
            rstat_r <= cfr_pkg::ST_PARTIAL; state_r <= S_RES;
          end else if (fill_r < FW'(2)) begin
            drop_r <= sat(drop_r); rstat_r <= cfr_pkg::ST_DROP; state_r <= S_RES;
          end else begin
            blen_r <= fill_r - FW'(2);
            ptr_r <= '0;
            state_r <= S_CRC;
          end
        end
        S_CRC: begin
          // Read the body byte by byte; the CRC unit folds the previous read.
          ptr_r <= ptr_inc;
          if (ptr_r == blen_r) begin
            state_r <= S_TRL;
          end else begin
            rdv_r <= 1'b1;
          end
        end
        S_TRL: begin
          // rdata first holds the trailer high byte, then the trailer low byte; rdv_r marks the second.
          rdv_r <= !rdv_r;
          if (!rdv_r) begin
            want_r <= rdata_r;
          end else begin
            if ({want_r, rdata_r} != crc) begin
              crcf_r <= sat(crcf_r); rstat_r <= cfr_pkg::ST_CRCFAIL;
              state_r <= S_RES;
            end else if (blen_r == '0) begin
              rstat_r <= cfr_pkg::ST_WORD; state_r <= S_RES;
            end else begin
              ptr_r <= '0; bcnt_r <= '0; wcnt_r <= '0; word_r <= '0;
              state_r <= S_OUT;
            end
          end
        end
        S_OUT: begin
          // Gather a word one byte per cycle, emit when full or at the end.
          if (rdv_r) begin
            word_r <= {rdata_r, word_r[63:8]};
            bcnt_r <= bcnt_r + 4'd1;
          end
          if (ptr_r != blen_r && !(rdv_r && bcnt_r == 4'd7) && bcnt_r != 4'd8) begin
            ptr_r <= ptr_inc; rdv_r <= 1'b1;
          end
          if (rdv_r && (bcnt_r == 4'd7 || ptr_r == blen_r)) begin
            out_valid_r <= 1'b1;
            out_status_r <= cfr_pkg::ST_WORD;
            out_word_r <= {rdata_r, word_r[63:8]} >> (6'(4'd7 - bcnt_r) * 8);
            out_nb_r <= bcnt_r + 4'd1;
            out_blen_r <= 9'(blen_r);
            out_last_r <= (ptr_r == blen_r) || (wcnt_r == 7'(cfr_pkg::WORD_LIMIT - 1));
            wcnt_r <= wcnt_r + 7'd1;
            bcnt_r <= '0; word_r <= '0;
            rdv_r <= 1'b0;
            if (ptr_r != blen_r && wcnt_r != 7'(cfr_pkg::WORD_LIMIT - 1)) begin
              ptr_r <= ptr_inc; rdv_r <= 1'b1;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        S_RES: begin
          out_valid_r <= 1'b1;
          out_status_r <= rstat_r;
          out_word_r <= '0; out_nb_r <= '0; out_blen_r <= '0; out_last_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_status = out_status_r;
  assign out_src_node = node_r;
  assign out_src_port = port_r;
  assign out_body_word = out_word_r;
  assign out_word_bytes = out_nb_r;
  assign out_body_length = out_blen_r;
  assign out_last = out_last_r;
  assign out_drop_count = drop_r;
  assign out_orphan_count = orph_r;
  assign out_crc_fail_count = crcf_r;

  `CFR_ASSERT_IMP(a_word_bytes, out_valid && out_status != cfr_pkg::ST_WORD, out_word_bytes == 4'd0, "non-word result with bytes")
  `CFR_ASSERT_IMP(a_nb_max, out_valid, out_word_bytes <= 4'd8, "word_bytes above eight")
  `CFR_ASSERT_NEXT(a_last_idle, out_valid && out_last, !out_valid, "result after last")
  `CFR_ASSERT_IMP(a_write_busy, we, busy, "store write while idle")
endmodule

/* tb/tb.sv */
// Self-checking testbench for can_fragment_reassembler_top.
// Frames are sent with the start/busy command handshake, and every result is checked
// against an in-bench reassembly predictor. Uses cfr_pkg and the RTL only.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT     = 4;
  localparam int BODY_MAX  = 512;
  localparam int STALL_LIM = 20000;

  // Kinds of damage a generated message may carry.
  localparam int FLAW_NONE = 0;
  localparam int FLAW_CRC  = 1;
  localparam int FLAW_SEQ  = 2;
  localparam int FLAW_SKIP = 3;
  localparam int FLAW_TAIL = 4;

  typedef struct {
    logic [28:0] id;
    logic [3:0]  len;
    logic [63:0] data;
  } frame_t;

  typedef struct {
    logic [2:0]  status;
    logic [7:0]  node;
    logic [7:0]  port;
    logic [63:0] word;
    logic [3:0]  nbytes;
    logic [8:0]  blen;
    logic        fin;
    logic [31:0] drops;
    logic [31:0] orphans;
    logic [31:0] crc_fails;
  } outcome_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [28:0] in_can_id = '0;
  logic [3:0]  in_frame_len = '0;
  logic [63:0] in_frame_data = '0;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [7:0]  out_src_node;
  logic [7:0]  out_src_port;
  logic [63:0] out_body_word;
  logic [3:0]  out_word_bytes;
  logic [8:0]  out_body_length;
  logic        out_last;
  logic [31:0] out_drop_count;
  logic [31:0] out_orphan_count;
  logic [31:0] out_crc_fail_count;

  can_fragment_reassembler_top u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_can_id(in_can_id), .in_frame_len(in_frame_len), .in_frame_data(in_frame_data),
    .out_valid(out_valid), .out_status(out_status), .out_src_node(out_src_node),
    .out_src_port(out_src_port), .out_body_word(out_body_word),
    .out_word_bytes(out_word_bytes), .out_body_length(out_body_length),
    .out_last(out_last), .out_drop_count(out_drop_count),
    .out_orphan_count(out_orphan_count), .out_crc_fail_count(out_crc_fail_count)
  );

  frame_t   frames_pending[$];
  outcome_t results_due[$];
  frame_t   lanes[3][$];
  int       errors = 0;
  int       frames_sent = 0;
  int       quiet_cycles = 0;

  // Predictor copy of the reassembly state.
  logic        sl_busy[NSLOT];
  logic [7:0]  sl_node[NSLOT];
  logic [7:0]  sl_port[NSLOT];
  logic [4:0]  sl_seq[NSLOT];
  logic [5:0]  sl_idx[NSLOT];
  int unsigned sl_fill[NSLOT];
  logic [7:0]  sl_bytes[NSLOT][BODY_MAX];
  logic [31:0] drops_seen = '0;
  logic [31:0] orphans_seen = '0;
  logic [31:0] crc_fails_seen = '0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] bump(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  // CRC-16/CCITT-FALSE computed bit by bit over a byte queue.
  function automatic logic [15:0] ccitt16(input logic [7:0] b[$], input int n);
    logic [15:0] r;
    logic        fb;
    r = 16'hFFFF;
    for (int i = 0; i < n; i++) begin
      for (int k = 7; k >= 0; k--) begin
        fb = r[15] ^ b[i][k];
        r = {r[14:0], 1'b0};
        if (fb) r = r ^ 16'h1021;
      end
    end
    return r;
  endfunction

  function automatic void note(input logic [2:0] st, input logic [7:0] nd, input logic [7:0] pt,
                               input logic [63:0] w, input logic [3:0] nb,
                               input logic [8:0] bl, input logic fin);
    outcome_t o;
    o.status = st; o.node = nd; o.port = pt; o.word = w; o.nbytes = nb;
    o.blen = bl; o.fin = fin; o.drops = drops_seen; o.orphans = orphans_seen;
    o.crc_fails = crc_fails_seen;
    results_due.push_back(o);
  endfunction

  // Works out the results of one accepted frame and updates the slot state.
  function automatic void reassemble(input frame_t f);
    logic [7:0]  nd, pt;
    logic        first, fin;
    logic [4:0]  sq;
    logic [5:0]  ix;
    int          n, s, bl, words, nb;
    logic [7:0]  body[$];
    logic [15:0] trailer;
    logic [63:0] w;
    nd = f.id[28:21]; pt = f.id[20:13]; first = f.id[12]; fin = f.id[11];
    sq = f.id[10:6]; ix = f.id[5:0];
    n = (f.len > 4'd8) ? 8 : int'(f.len);
    s = -1;
    for (int i = 0; i < NSLOT; i++)
      if (s < 0 && sl_busy[i] && sl_node[i] == nd && sl_port[i] == pt) s = i;
    if (first) begin
      if (s < 0)
        for (int i = 0; i < NSLOT; i++) if (s < 0 && !sl_busy[i]) s = i;
      if (s < 0) begin
        drops_seen = bump(drops_seen);
        note(cfr_pkg::ST_DROP, nd, pt, '0, '0, '0, 1'b1);
        return;
      end
      sl_busy[s] = 1'b1; sl_node[s] = nd; sl_port[s] = pt; sl_seq[s] = sq;
      sl_idx[s] = '0; sl_fill[s] = 0;
    end else if (s < 0) begin
      orphans_seen = bump(orphans_seen);
      note(cfr_pkg::ST_ORPHAN, nd, pt, '0, '0, '0, 1'b1);
      return;
    end
    if (ix != sl_idx[s] || sq != sl_seq[s] || sl_fill[s] + n > BODY_MAX) begin
      drops_seen = bump(drops_seen);
      sl_busy[s] = 1'b0;
      note(cfr_pkg::ST_DROP, nd, pt, '0, '0, '0, 1'b1);
      return;
    end
    for (int j = 0; j < n; j++) sl_bytes[s][sl_fill[s] + j] = f.data[8*j +: 8];
    sl_fill[s] += n;
    sl_idx[s] = sl_idx[s] + 6'd1;
    if (!fin) begin
      note(cfr_pkg::ST_PARTIAL, nd, pt, '0, '0, '0, 1'b1);
      return;
    end
    sl_busy[s] = 1'b0;
    if (sl_fill[s] < 2) begin
      drops_seen = bump(drops_seen);
      note(cfr_pkg::ST_DROP, nd, pt, '0, '0, '0, 1'b1);
      return;
    end
    bl = sl_fill[s] - 2;
    for (int j = 0; j < bl; j++) body.push_back(sl_bytes[s][j]);
    trailer = {sl_bytes[s][bl], sl_bytes[s][bl+1]};
    if (trailer != ccitt16(body, bl)) begin
      crc_fails_seen = bump(crc_fails_seen);
      note(cfr_pkg::ST_CRCFAIL, nd, pt, '0, '0, '0, 1'b1);
      return;
    end
    words = (bl + 7) / 8;
    if (words > 64) words = 64;
    if (words == 0) begin
      note(cfr_pkg::ST_WORD, nd, pt, '0, '0, '0, 1'b1);
      return;
    end
    for (int k = 0; k < words; k++) begin
      nb = (bl - 8*k > 8) ? 8 : bl - 8*k;
      w = '0;
      for (int j = 0; j < nb; j++) w[8*j +: 8] = body[8*k + j];
      note(cfr_pkg::ST_WORD, nd, pt, w, nb[3:0], bl[8:0], k + 1 == words);
    end
  endfunction

  function automatic frame_t mk(input logic [7:0] nd, input logic [7:0] pt, input logic first,
                                input logic fin, input logic [4:0] sq, input logic [5:0] ix,
                                input logic [3:0] n, input logic [63:0] d);
    frame_t f;
    f.id = {nd, pt, first, fin, sq, ix};
    f.len = n;
    f.data = d;
    return f;
  endfunction

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  // Builds one message with its trailer and splits it into frames on a lane.
  // The flaw may corrupt a byte, bump a sequence, skip an index or leave off the tail.
  task automatic build_message(input int lane, input logic [7:0] nd, input logic [7:0] pt,
                               input int bl, input int flaw, input logic big_chunks);
    logic [7:0]  msg[$];
    logic [15:0] c;
    logic [4:0]  sq;
    logic [5:0]  ix;
    logic [63:0] d;
    int          pos, n, total, nfr, bad;
    for (int i = 0; i < bl; i++) msg.push_back(8'($urandom_range(0, 255)));
    c = ccitt16(msg, bl);
    msg.push_back(c[15:8]);
    msg.push_back(c[7:0]);
    total = bl + 2;
    if (flaw == FLAW_CRC) msg[$urandom_range(0, total - 1)] ^= 8'h01 << $urandom_range(0, 7);
    sq = 5'($urandom_range(0, 31));
    ix = '0;
    pos = 0;
    nfr = 0;
    bad = -1;
    while (pos < total || nfr == 0) begin
      n = big_chunks ? 8 : (($urandom_range(0, 99) < 60) ? 8 : $urandom_range(0, 8));
      if (n > total - pos) n = total - pos;
      d = rnd64();
      for (int j = 0; j < n; j++) d[8*j +: 8] = msg[pos + j];
      pos += n;
      if (flaw == FLAW_TAIL && pos >= total && nfr > 0) break;
      if (bad < 0 && nfr > 0 && (flaw == FLAW_SEQ || flaw == FLAW_SKIP)
          && $urandom_range(0, 2) == 0) bad = nfr;
      if (bad < 0 && pos >= total && (flaw == FLAW_SEQ || flaw == FLAW_SKIP)) bad = nfr;
      lanes[lane].push_back(mk(nd, pt, nfr == 0, pos >= total,
                               (bad == nfr && flaw == FLAW_SEQ) ? sq + 5'd1 : sq,
                               (bad == nfr && flaw == FLAW_SKIP) ? ix + 6'd2 : ix,
                               n[3:0], d));
      ix = ix + 6'd1;
      nfr++;
    end
  endtask

  // Mixes the lanes' frames in random order, keeping each lane's own order.
  task automatic merge_lanes();
    int k;
    while (lanes[0].size() + lanes[1].size() + lanes[2].size() > 0) begin
      k = $urandom_range(0, 2);
      if (lanes[k].size() > 0) frames_pending.push_back(lanes[k].pop_front());
    end
  endtask

  function automatic logic [7:0] pick_id();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h55;
      3: return 8'hAA;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Stimulus: directed corner frames, then random interleaved messages and stray frames.
  initial begin
    int lanes_now, pick;
    for (int i = 0; i < NSLOT; i++) begin
      sl_busy[i] = 1'b0; sl_node[i] = '0; sl_port[i] = '0;
      sl_seq[i] = '0; sl_idx[i] = '0; sl_fill[i] = 0;
    end
    // Empty body: only the trailer of an empty CRC.
    frames_pending.push_back(mk(8'h00, 8'h00, 1'b1, 1'b1, 5'd0, 6'd0, 4'd2,
                                64'h0000_0000_0000_FFFF));
    // Short body: one byte on a last fragment.
    frames_pending.push_back(mk(8'hFF, 8'hFF, 1'b1, 1'b1, 5'd31, 6'd0, 4'd1,
                                64'hFFFF_FFFF_FFFF_FFFF));
    // Stray fragment with no open slot, and an oversized length.
    frames_pending.push_back(mk(8'h12, 8'h34, 1'b0, 1'b1, 5'd3, 6'd63, 4'd15,
                                64'hFFFF_FFFF_FFFF_FFFF));
    frames_pending.push_back(mk(8'h01, 8'h02, 1'b1, 1'b1, 5'd0, 6'd0, 4'd9, rnd64()));
    // Every slot busy: the fifth open body is dropped.
    for (int i = 0; i < 5; i++)
      frames_pending.push_back(mk(8'h40, i[7:0], 1'b1, 1'b0, 5'd1, 6'd0, 4'd8, rnd64()));
    // Re-seeding an open slot, then finishing it with an index out of order.
    frames_pending.push_back(mk(8'h40, 8'h00, 1'b1, 1'b0, 5'd2, 6'd0, 4'd3, rnd64()));
    frames_pending.push_back(mk(8'h40, 8'h00, 1'b0, 1'b1, 5'd2, 6'd5, 4'd3, rnd64()));
    frames_pending.push_back(mk(8'h40, 8'h01, 1'b0, 1'b0, 5'd9, 6'd1, 4'd0, rnd64()));
    frames_pending.push_back(mk(8'h40, 8'h02, 1'b0, 1'b1, 5'd1, 6'd1, 4'd0, rnd64()));
    frames_pending.push_back(mk(8'h40, 8'h03, 1'b0, 1'b1, 5'd1, 6'd1, 4'd8, rnd64()));
    build_message(0, 8'h7E, 8'h81, 6, FLAW_NONE, 1'b0);
    build_message(1, 8'h7E, 8'h82, 9, FLAW_CRC, 1'b0);
    merge_lanes();

    // Largest body and one overflow, sent once each.
    build_message(0, 8'hC3, 8'h3C, 510, FLAW_NONE, 1'b1);
    merge_lanes();
    build_message(0, 8'hC3, 8'h3D, 515, FLAW_NONE, 1'b1);
    merge_lanes();

    while (frames_pending.size() < 380) begin
      if ($urandom_range(0, 99) < 12) begin
        frames_pending.push_back(mk(pick_id(), pick_id(), 1'($urandom_range(0, 1)),
                                    1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)),
                                    6'($urandom_range(0, 63)), 4'($urandom_range(0, 15)),
                                    rnd64()));
      end else begin
        lanes_now = $urandom_range(1, 3);
        for (int k = 0; k < lanes_now; k++) begin
          pick = $urandom_range(0, 99);
          build_message(k, pick_id(), 8'(k * 16 + $urandom_range(0, 3)),
                        ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                    : $urandom_range(0, 30),
                        (pick < 70) ? FLAW_NONE : $urandom_range(FLAW_CRC, FLAW_TAIL), 1'b0);
        end
        merge_lanes();
      end
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    wait (frames_pending.size() == 0 && results_due.size() == 0);
    repeat (1100) @(posedge clk);
    if (errors == 0 && results_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Driver: offers the head frame, idling at random outside a calm stretch.
  always @(posedge clk) begin
    logic go;
    if (rst_n) begin
      if (start && !busy) begin
        reassemble(frames_pending.pop_front());
        frames_sent++;
      end
      if (start && busy) go = 1'b1;
      else go = frames_pending.size() > 0 &&
                ((frames_sent > 150 && frames_sent < 240) || $urandom_range(0, 99) >= 23);
      start <= go;
      if (go) begin
        in_can_id     <= frames_pending[0].id;
        in_frame_len  <= frames_pending[0].len;
        in_frame_data <= frames_pending[0].data;
      end
    end
  end

  // Monitor: each result transaction is checked against the oldest expectation.
  always @(posedge clk) begin
    outcome_t e;
    if (rst_n && out_valid) begin
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result, status %0d", $time, out_status);
        errors++;
      end else begin
        e = results_due.pop_front();
        if ({out_status, out_src_node, out_src_port, out_body_word, out_word_bytes,
             out_body_length, out_last, out_drop_count, out_orphan_count,
             out_crc_fail_count} !==
            {e.status, e.node, e.port, e.word, e.nbytes, e.blen, e.fin, e.drops,
             e.orphans, e.crc_fails}) begin
          $display("%0t: exp st=%0d node=%h port=%h word=%h nb=%0d len=%0d last=%b c=%0d/%0d/%0d",
                   $time, e.status, e.node, e.port, e.word, e.nbytes, e.blen, e.fin,
                   e.drops, e.orphans, e.crc_fails);
          $display("%0t: got st=%0d node=%h port=%h word=%h nb=%0d len=%0d last=%b c=%0d/%0d/%0d",
                   $time, out_status, out_src_node, out_src_port, out_body_word,
                   out_word_bytes, out_body_length, out_last, out_drop_count,
                   out_orphan_count, out_crc_fail_count);
          errors++;
        end
      end
    end
  end

  // Watchdog: too long with no transaction on either side ends the run.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIM) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

/* sim.f */
+incdir+hdl
hdl/cfr_pkg.sv
hdl/cfr_crc.sv
hdl/can_fragment_reassembler_top.sv
tb/tb.sv
